FILE: hw/rtl/planar_odometry_integrator_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the planar odometry integrator
// Shared property templates that report through $error.
// ----------------------------------------------------------------------------
`ifndef PLANAR_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_UNIT_MACROS_SVH

// Consequence holds in the same cycle as the antecedent.
`define POI_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define POI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/poi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator package
// Shared multiplier widths, sine coefficients and sequencer state type.
// ----------------------------------------------------------------------------
package poi_pkg;

   // Shared multiplier operand and product widths.
   localparam int MUL_W  = 35;
   localparam int PROD_W = 2 * MUL_W;

   // Taylor coefficients of sin(pi/2*u) in Q30, for u^1, u^3, u^5, u^7, u^9.
   localparam logic [31:0] SIN_COEF [5] = '{
      32'd1686629713, 32'd693598668, 32'd85569306, 32'd5026995, 32'd172272
   };

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_TRIG = 5'b00010,
      ST_MOVE = 5'b00100,
      ST_FIN  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

endpackage

FILE: hw/rtl/poi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared signed multiplier
// One signed multiply per cycle with a registered product.
// ----------------------------------------------------------------------------
module poi_mul
   import poi_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   // Full-width signed product.
   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: hw/rtl/planar_odometry_integrator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator
// Dead-reckoning pose integration with a yaw quaternion output.
// ----------------------------------------------------------------------------
// One request is worked on at a time. The next request can be accepted in
// the cycle after the result is taken. The work is paced by the single shared
// 35x35 multiplier: a sine/cosine pair of the heading (the two Horner chains
// interleaved), the rotation and scaling products, a sine/cosine pair of the
// half heading and a final step to round the quaternion. The sine polynomial
// is evaluated in Q30 and the rotation uses sine and cosine rounded to
// TRIG_BITS fraction bits.
`include "planar_odometry_integrator_unit_macros.svh"

module planar_odometry_integrator_unit
   import poi_pkg::*;
#(
   parameter int TRIG_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_body_vel_x,
   input  logic signed [31:0] req_body_vel_y,
   input  logic signed [31:0] req_turn_rate,
   input  logic [21:0]        req_elapsed,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [47:0] rsp_pos_x,
   output logic signed [47:0] rsp_pos_y,
   output logic [31:0]        rsp_yaw,
   output logic signed [15:0] rsp_quat_z,
   output logic signed [15:0] rsp_quat_w
);

   localparam int TW    = TRIG_BITS + 2;
   localparam int TSH   = 30 - TRIG_BITS;
   localparam int TRND  = 1 << (TSH - 1);
   localparam int ACC_W = TRIG_BITS + 35;
   localparam int WRND  = 1 << (TRIG_BITS - 1);
   localparam logic [3:0] TRIG_LAST = 4'd12;
   localparam logic [3:0] MOVE_LAST = 4'd8;

   // Sequencer state.
   state_type state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic       pass_ff, pass_in;

   // Request and pose registers.
   logic signed [31:0] vx_ff, vy_ff, rate_ff;
   logic [21:0]        dt_ff;
   logic signed [47:0] x_ff, x_in, y_ff, y_in;
   logic [31:0]        head_ff, head_in;

   // Sine lanes and rotation intermediates.
   logic [30:0]        u_ff   [2];
   logic               neg_ff [2];
   logic [30:0]        u2_ff  [2];
   logic [31:0]        t_ff   [2];
   logic signed [31:0] sig_ff [2];
   logic signed [TW-1:0]    sin_ff, cos_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [MUL_W-1:0] wx_ff, wy_ff;
   logic signed [15:0]      qz_ff, qw_ff;

   // Multiplier connection.
   logic signed [MUL_W-1:0]  op_a, op_b;
   logic signed [PROD_W-1:0] prod;

   // Decoded step fields.
   logic       iss_lane, wb_lane;
   logic [2:0] iss_phase, wb_phase;
   logic [3:0] step_m1;

   // Combinational arithmetic on the product and lanes.
   logic [31:0]             prod_q30;
   logic [31:0]             sine_mag;
   logic signed [31:0]      sin_sum, cos_sum;
   logic signed [ACC_W-1:0] rot_sum, rot_rnd;
   logic signed [PROD_W-1:0] step_rnd;
   logic signed [35:0]      pos_step;
   logic signed [48:0]      pos_sum;
   logic signed [47:0]      pos_sat;
   logic signed [47:0]      pos_base;
   logic [31:0]             half;
   logic signed [31:0]      qz_sum, qw_sum;
   logic signed [16:0]      qz_raw, qw_raw;

   logic req_take, rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_OUT);
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign iss_lane  = step_ff[0];
   assign iss_phase = step_ff[3:1];
   assign step_m1   = step_ff - 4'd1;
   assign wb_lane   = step_m1[0];
   assign wb_phase  = step_m1[3:1];

   poi_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // Operand selection for the shared multiplier.
   always_comb begin
      op_a = '0;
      op_b = '0;
      if (state_ff == ST_TRIG) begin
         unique case (iss_phase)
            3'd0: begin
               op_a = MUL_W'(u_ff[iss_lane]);
               op_b = MUL_W'(u_ff[iss_lane]);
            end
            3'd1: begin
               op_a = MUL_W'(u2_ff[iss_lane]);
               op_b = MUL_W'(SIN_COEF[4]);
            end
            3'd2, 3'd3, 3'd4: begin
               op_a = MUL_W'(u2_ff[iss_lane]);
               op_b = MUL_W'(t_ff[iss_lane]);
            end
            3'd5: begin
               op_a = MUL_W'(u_ff[iss_lane]);
               op_b = MUL_W'(t_ff[iss_lane]);
            end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end else if (state_ff == ST_MOVE) begin
         unique case (step_ff)
            4'd1: begin op_a = MUL_W'(vx_ff);   op_b = MUL_W'(cos_ff); end
            4'd2: begin op_a = MUL_W'(vy_ff);   op_b = MUL_W'(sin_ff); end
            4'd3: begin op_a = MUL_W'(vx_ff);   op_b = MUL_W'(sin_ff); end
            4'd4: begin op_a = MUL_W'(vy_ff);   op_b = MUL_W'(cos_ff); end
            4'd5: begin op_a = MUL_W'(rate_ff); op_b = MUL_W'(dt_ff);  end
            4'd6: begin op_a = wx_ff;           op_b = MUL_W'(dt_ff);  end
            4'd7: begin op_a = wy_ff;           op_b = MUL_W'(dt_ff);  end
            default: begin
               op_a = '0;
               op_b = '0;
            end
         endcase
      end
   end

   // Product in Q30 and the clamped quarter-wave sine.
   assign prod_q30 = prod[61:30];
   assign sine_mag = (prod_q30 > 32'(Q30_ONE)) ? 32'(Q30_ONE) : prod_q30;

   // Sine and cosine rounded to the rotation precision.
   assign sin_sum = sig_ff[0] + 32'(TRND);
   assign cos_sum = sig_ff[1] + 32'(TRND);

   // Rotated velocity: accumulate the two products, then round.
   always_comb begin
      if (step_ff == 4'd3) begin
         rot_sum = acc_ff - ACC_W'(prod);
      end else begin
         rot_sum = acc_ff + ACC_W'(prod);
      end
      rot_rnd = (rot_sum + ACC_W'(WRND)) >>> TRIG_BITS;
   end

   // Scaled step by elapsed time, rounded from 2^-20 s.
   assign step_rnd = (prod + PROD_W'(20'h8_0000)) >>> 20;
   assign pos_step = 36'(step_rnd);

   // Saturating position update, shared by x and y.
   always_comb begin
      pos_base = (step_ff == 4'd7) ? x_ff : y_ff;
      pos_sum  = 49'(pos_base) + 49'(pos_step);
      if (pos_sum[48] != pos_sum[47]) begin
         pos_sat = pos_sum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
      end else begin
         pos_sat = pos_sum[47:0];
      end
   end

   assign half = {1'b0, head_ff[31:1]};

   // Quaternion rounding to Q1.15, with plus one saturated.
   assign qz_sum = sig_ff[0] + 32'sd16384;
   assign qw_sum = sig_ff[1] + 32'sd16384;
   assign qz_raw = 17'(qz_sum >>> 15);
   assign qw_raw = 17'(qw_sum >>> 15);

   // Next-state logic of the sequencer and pose.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      pass_in  = pass_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      head_in  = head_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_TRIG;
               step_in  = '0;
               pass_in  = 1'b0;
            end
         end
         ST_TRIG: begin
            step_in = step_ff + 4'd1;
            if (step_ff == TRIG_LAST) begin
               step_in  = '0;
               state_in = pass_ff ? ST_FIN : ST_MOVE;
            end
         end
         ST_MOVE: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd6) begin
               head_in = head_ff + step_rnd[31:0];
            end
            if (step_ff == 4'd7) begin
               x_in = pos_sat;
            end
            if (step_ff == MOVE_LAST) begin
               y_in     = pos_sat;
               step_in  = '0;
               pass_in  = 1'b1;
               state_in = ST_TRIG;
            end
         end
         ST_FIN: begin
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_take) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and pose registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         pass_ff  <= 1'b0;
         x_ff     <= '0;
         y_ff     <= '0;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         pass_ff  <= pass_in;
         x_ff     <= x_in;
         y_ff     <= y_in;
         head_ff  <= head_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         vx_ff     <= req_body_vel_x;
         vy_ff     <= req_body_vel_y;
         rate_ff   <= req_turn_rate;
         dt_ff     <= req_elapsed;
         // Lanes start on the heading and the heading plus a quarter turn.
         u_ff[0]   <= head_ff[30] ? (Q30_ONE - {1'b0, head_ff[29:0]})
                                  : {1'b0, head_ff[29:0]};
         neg_ff[0] <= head_ff[31];
         u_ff[1]   <= head_ff[30] ? {1'b0, head_ff[29:0]}
                                  : (Q30_ONE - {1'b0, head_ff[29:0]});
         neg_ff[1] <= head_ff[31] ^ head_ff[30];
      end
      if (state_ff == ST_TRIG && step_ff != 4'd0) begin
         unique case (wb_phase)
            3'd0: u2_ff[wb_lane] <= prod[60:30];
            3'd1, 3'd2, 3'd3, 3'd4: begin
               t_ff[wb_lane] <= SIN_COEF[3'd4 - wb_phase] - prod_q30;
            end
            3'd5: begin
               sig_ff[wb_lane] <= neg_ff[wb_lane] ? -$signed(sine_mag)
                                                  : $signed(sine_mag);
            end
            default: begin
               t_ff[wb_lane] <= t_ff[wb_lane];
            end
         endcase
      end
      if (state_ff == ST_MOVE) begin
         unique case (step_ff)
            4'd0: begin
               sin_ff <= TW'(sin_sum >>> TSH);
               cos_ff <= TW'(cos_sum >>> TSH);
            end
            4'd2, 4'd4: acc_ff <= ACC_W'(prod);
            4'd3: wx_ff <= MUL_W'(rot_rnd);
            4'd5: wy_ff <= MUL_W'(rot_rnd);
            4'd8: begin
               // Lanes restart on the half heading for the quaternion.
               u_ff[0]   <= half[30] ? (Q30_ONE - {1'b0, half[29:0]})
                                     : {1'b0, half[29:0]};
               neg_ff[0] <= half[31];
               u_ff[1]   <= half[30] ? {1'b0, half[29:0]}
                                     : (Q30_ONE - {1'b0, half[29:0]});
               neg_ff[1] <= half[31] ^ half[30];
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
      if (state_ff == ST_FIN) begin
         qz_ff <= (!qz_raw[16] && qz_raw[15]) ? 16'sh7fff : qz_raw[15:0];
         qw_ff <= (!qw_raw[16] && qw_raw[15]) ? 16'sh7fff : qw_raw[15:0];
      end
   end

   assign rsp_pos_x  = x_ff;
   assign rsp_pos_y  = y_ff;
   assign rsp_yaw    = head_ff;
   assign rsp_quat_z = qz_ff;
   assign rsp_quat_w = qw_ff;

   // Sequencing checks.
   `POI_ASSERT_NEXT(a_take_starts_trig, clock, reset, req_take,
      (state_ff == ST_TRIG) && (step_ff == 4'd0) && !pass_ff,
      "accepted request did not start the trig pass")
   `POI_ASSERT_SAME(a_no_take_with_rsp, clock, reset, req_take, !rsp_valid,
      "request accepted while a result is pending")
   `POI_ASSERT_NEXT(a_one_result, clock, reset, rsp_take, !rsp_valid,
      "result shown twice for one request")
   `POI_ASSERT_SAME(a_trig_step_range, clock, reset, state_ff == ST_TRIG,
      step_ff <= TRIG_LAST, "trig step counter out of range")

endmodule

FILE: dv/odometry_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Odometry result checker
// Watches the request and result channels, integrates its own copy of the
// pose for each accepted request and compares every result field by field.
// ----------------------------------------------------------------------------
module odometry_checker #(
   parameter int TRIG_BITS = 16
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_body_vel_x,
   input  logic signed [31:0] req_body_vel_y,
   input  logic signed [31:0] req_turn_rate,
   input  logic [21:0]        req_elapsed,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [47:0] rsp_pos_x,
   input  logic signed [47:0] rsp_pos_y,
   input  logic [31:0]        rsp_yaw,
   input  logic signed [15:0] rsp_quat_z,
   input  logic signed [15:0] rsp_quat_w,
   output int                 error_count,
   output int                 pending_count,
   output int                 result_count
);

   typedef struct packed {
      logic signed [47:0] pos_x;
      logic signed [47:0] pos_y;
      logic [31:0]        yaw;
      logic signed [15:0] quat_z;
      logic signed [15:0] quat_w;
   } pose_type;

   localparam longint POS_HI = 64'sd140737488355327;
   localparam longint POS_LO = -64'sd140737488355328;
   localparam longint Q30_UNIT = 64'sd1073741824;

   // Taylor coefficients of sin(pi/2*u) in Q30, lowest power first.
   localparam longint COEF_U1 = 1686629713;
   localparam longint COEF_U3 = 693598668;
   localparam longint COEF_U5 = 85569306;
   localparam longint COEF_U7 = 5026995;
   localparam longint COEF_U9 = 172272;

   pose_type expected_poses[$];
   longint track_x;
   longint track_y;
   logic [31:0] track_heading;

   // Round half toward plus infinity; arithmetic shift is a floor.
   function automatic longint round_shift(input longint v, input int n);
      return (v + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   // Sine of a binary angle in Q30 by quadrant folding and a Horner chain.
   function automatic longint angle_sine(input logic [31:0] a);
      logic [63:0] u, u2, t;
      longint mag;
      u = {34'd0, a[29:0]};
      if (a[30]) u = 64'h4000_0000 - u;
      u2 = (u * u) >> 30;
      t = COEF_U9;
      t = COEF_U7 - ((u2 * t) >> 30);
      t = COEF_U5 - ((u2 * t) >> 30);
      t = COEF_U3 - ((u2 * t) >> 30);
      t = COEF_U1 - ((u2 * t) >> 30);
      t = (u * t) >> 30;
      mag = (t > 64'h4000_0000) ? Q30_UNIT : longint'(t);
      return a[31] ? -mag : mag;
   endfunction

   function automatic logic signed [15:0] to_q15(input longint q30);
      longint v;
      v = round_shift(q30, 15);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic longint clamp_pos(input longint v);
      if (v > POS_HI) return POS_HI;
      if (v < POS_LO) return POS_LO;
      return v;
   endfunction

   // Advance the pose by one tick and return the pose the block must emit.
   function automatic pose_type integrate_tick(input longint vx, input longint vy,
                                               input longint rate, input longint dt);
      longint s, c, wx, wy, dth;
      logic [31:0] half;
      pose_type p;
      s = round_shift(angle_sine(track_heading), 30 - TRIG_BITS);
      c = round_shift(angle_sine(track_heading + 32'h4000_0000), 30 - TRIG_BITS);
      wx = round_shift(vx * c - vy * s, TRIG_BITS);
      wy = round_shift(vx * s + vy * c, TRIG_BITS);
      dth = round_shift(rate * dt, 20);
      track_x = clamp_pos(track_x + round_shift(wx * dt, 20));
      track_y = clamp_pos(track_y + round_shift(wy * dt, 20));
      track_heading = track_heading + dth[31:0];
      half = track_heading >> 1;
      p.pos_x = track_x[47:0];
      p.pos_y = track_y[47:0];
      p.yaw = track_heading;
      p.quat_z = to_q15(angle_sine(half));
      p.quat_w = to_q15(angle_sine(half + 32'h4000_0000));
      return p;
   endfunction

   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   assign pending_count = expected_poses.size();

   // Predict on accepted requests, compare on accepted results.
   always @(posedge clock) begin
      pose_type want;
      if (reset) begin
         track_x = 0;
         track_y = 0;
         track_heading = 0;
         expected_poses.delete();
         error_count = 0;
         result_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            result_count++;
            if (expected_poses.size() == 0) begin
               $display("%0t: result with no request outstanding", $time);
               error_count++;
            end else begin
               want = expected_poses.pop_front();
               if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
               if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
               if (rsp_yaw !== want.yaw) report_mismatch("yaw", rsp_yaw, want.yaw);
               if (rsp_quat_z !== want.quat_z)
                  report_mismatch("quat_z", rsp_quat_z, want.quat_z);
               if (rsp_quat_w !== want.quat_w)
                  report_mismatch("quat_w", rsp_quat_w, want.quat_w);
            end
         end
         if (req_valid && !req_stall)
            expected_poses.push_back(integrate_tick(req_body_vel_x, req_body_vel_y,
                                                    req_turn_rate, req_elapsed));
      end
   end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Planar odometry integrator testbench
// Drives directed and random ticks with random idling on both channels and
// takes the verdict from the result checker.
// ----------------------------------------------------------------------------
module tb_top;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic signed [31:0] req_body_vel_x = 0;
   logic signed [31:0] req_body_vel_y = 0;
   logic signed [31:0] req_turn_rate = 0;
   logic [21:0]        req_elapsed = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [47:0] rsp_pos_x;
   logic signed [47:0] rsp_pos_y;
   logic [31:0]        rsp_yaw;
   logic signed [15:0] rsp_quat_z;
   logic signed [15:0] rsp_quat_w;
   int                 error_count;
   int                 pending_count;
   int                 result_count;
   logic               calm_stretch = 0;

   localparam int RANDOM_TICKS = 2000;

   always #1 clock = ~clock;

   planar_odometry_integrator_unit dut (.*);

   odometry_checker checker_inst (.*);

   // The result side stalls at random, except during the calm stretch.
   always @(posedge clock)
      rsp_stall <= !calm_stretch && ($urandom_range(99) < 15);

   // Present one request and hold it until accepted; valid drops only while idling.
   task automatic send_tick(input logic [31:0] vx, input logic [31:0] vy,
                            input logic [31:0] rate, input logic [21:0] dt);
      while (!calm_stretch && $urandom_range(99) < 15) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_body_vel_x <= vx;
      req_body_vel_y <= vy;
      req_turn_rate <= rate;
      req_elapsed <= dt;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      unique case ($urandom_range(5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return $urandom_range(2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: zero time, extremes, quadrant boundaries and saturation.
      send_tick(0, 0, 0, 22'd0);
      send_tick(32'h0001_0000, 0, 0, 22'h10_0000);
      send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 22'h3F_FFFF);
      send_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 22'h3F_FFFF);
      send_tick(0, 32'h0001_0000, 32'h4000_0000, 22'h10_0000);
      send_tick(32'h0001_0000, 32'hFFFF_0000, 32'h4000_0000, 22'h10_0000);
      send_tick(32'h0001_0000, 32'h0001_0000, 32'h4000_0000, 22'h10_0000);
      send_tick(32'h0001_0000, 0, 32'h4000_0000, 22'h10_0000);
      send_tick(32'h1234_5678, 32'h8765_4321, 32'h7FFF_FFFF, 22'd0);
      send_tick(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 22'h00_0001);
      // Drive both axes hard toward the position limits, in both directions.
      repeat (4) send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 22'h3F_FFFF);
      send_tick(0, 0, 32'h8000_0000, 22'h10_0000);
      repeat (4) send_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 22'h3F_FFFF);
      send_tick(0, 0, 32'hC000_0000, 22'h08_0000);
      send_tick(0, 0, 32'hFFFF_FFFF, 22'h3F_FFFF);
      req_valid <= 0;

      // Hold off until every expected result has come back.
      while (pending_count != 0) @(posedge clock);

      // Random ticks, with a calm stretch without any idling in the middle.
      for (int i = 0; i < RANDOM_TICKS; i++) begin
         calm_stretch <= (i >= 800 && i < 1000);
         send_tick(pick_word(), pick_word(), pick_word(),
                   ($urandom_range(3) == 0) ? 22'($urandom_range(22'h3F_FFFF))
                                            : 22'($urandom_range(22'h1_0000)));
      end
      calm_stretch <= 0;
      req_valid <= 0;

      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("Covered %0d results: directed extremes, saturation, heading wrap,",
               result_count);
      $display("zero elapsed time and random ticks with stalls on both channels.");
      if (error_count == 0 && pending_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2000000;
      $display("Timed out with %0d results outstanding.", pending_count);
      $display("== FAIL ==");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/poi_pkg.sv
hw/rtl/poi_mul.sv
hw/rtl/planar_odometry_integrator_unit.sv
dv/odometry_checker.sv
dv/tb_top.sv
